[rtl/sks_pkg.sv]
// ----------------------------------------------------------------------------
// sks_pkg
// Shared widths, constants and register codes of the I/Q Kalman smoother.
// ----------------------------------------------------------------------------
package sks_pkg;

    localparam int SAMPLE_BITS   = 16;
    localparam int EST_FRAC      = 8;
    localparam int EST_BITS      = SAMPLE_BITS + EST_FRAC;
    localparam int VAR_BITS      = 24;
    localparam int VAR_FRAC_BITS = 16;
    localparam int GAIN_BITS     = VAR_FRAC_BITS + 1;
    localparam int DEN_BITS      = VAR_BITS + 1;
    localparam int REM_BITS      = DEN_BITS + 1;
    localparam int DIV_STEPS     = GAIN_BITS;
    localparam int CNT_BITS      = $clog2(DIV_STEPS);
    localparam int PROD_BITS     = EST_BITS + 1 + GAIN_BITS;
    localparam int VPROD_BITS    = GAIN_BITS + VAR_BITS;

    localparam logic [GAIN_BITS-1:0] GAIN_ONE = GAIN_BITS'(1) << VAR_FRAC_BITS;
    localparam logic [VAR_BITS-1:0]  VAR_MAX  = '1;

    localparam logic [VAR_BITS-1:0]    Q_RESET = VAR_BITS'(655);
    localparam logic [VAR_BITS-1:0]    R_RESET = VAR_BITS'(65536);
    localparam logic [SAMPLE_BITS-1:0] X_RESET = '0;
    localparam logic [VAR_BITS-1:0]    P_RESET = VAR_BITS'(65536);

    localparam int ADDR_BITS = 4;

    typedef enum logic [1:0] {
        REG_Q_NOISE = 2'd0,
        REG_R_NOISE = 2'd1,
        REG_X_INIT  = 2'd2,
        REG_P_INIT  = 2'd3
    } cfg_reg_t;

endpackage

[rtl/sks_divider.sv]
// ----------------------------------------------------------------------------
// sks_divider
// Radix-2 restoring divider for the gain: floor(ppred * 2^F / den).
// ----------------------------------------------------------------------------
module sks_divider
    import sks_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [VAR_BITS-1:0]  ppred,
    input  logic [DEN_BITS-1:0]  den,
    output logic                 done,
    output logic [GAIN_BITS-1:0] gain
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [REM_BITS-1:0]  rem_reg, rem_next;
    logic [GAIN_BITS-1:0] quo_reg, quo_next;
    logic [REM_BITS-1:0]  den_ext;
    logic [REM_BITS-1:0]  rem_sub;
    logic                 ge;

    assign den_ext = REM_BITS'(den);
    assign ge      = rem_reg >= den_ext;
    assign rem_sub = ge ? rem_reg - den_ext : rem_reg;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start) begin
            if (den == '0) begin
                quo_next  = '0;
                done_next = 1'b1;
            end else begin
                rem_next  = REM_BITS'(ppred);
                quo_next  = '0;
                cnt_next  = CNT_BITS'(DIV_STEPS - 1);
                busy_next = 1'b1;
            end
        end else if (busy_reg) begin
            rem_next = {rem_sub[REM_BITS-2:0], 1'b0};
            quo_next = {quo_reg[GAIN_BITS-2:0], ge};
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign gain = quo_reg;

`ifndef SYNTHESIS
    a_gain_range: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> quo_reg <= GAIN_ONE)
        else $error("gain above one");
    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !start)
        else $error("divider restarted while busy");
`endif

endmodule

[rtl/sks_lane.sv]
// ----------------------------------------------------------------------------
// sks_lane
// One estimate lane: correction multiply, estimate update and output rounding.
// ----------------------------------------------------------------------------
module sks_lane
    import sks_pkg::*;
(
    input  logic                          aclk,
    input  logic                          mul_en,
    input  logic signed [EST_BITS-1:0]    est,
    input  logic signed [SAMPLE_BITS-1:0] sample,
    input  logic        [GAIN_BITS-1:0]   gain,
    output logic signed [EST_BITS-1:0]    est_next,
    output logic signed [SAMPLE_BITS-1:0] est_round
);

    logic signed [EST_BITS:0]    diff;
    logic        [EST_BITS:0]    mag;
    logic                        neg_reg;
    logic        [PROD_BITS-1:0] prod_reg;
    logic        [PROD_BITS:0]   prod_rnd;
    logic        [EST_BITS+1:0]  corr;
    logic signed [EST_BITS+2:0]  est_ext;
    logic signed [EST_BITS+2:0]  corr_ext;
    logic signed [EST_BITS+2:0]  sum;
    logic signed [EST_BITS:0]    rnd;

    assign diff = (EST_BITS+1)'($signed({sample, {EST_FRAC{1'b0}}})) - (EST_BITS+1)'(est);
    assign mag  = diff[EST_BITS] ? $unsigned(-diff) : $unsigned(diff);

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            neg_reg  <= diff[EST_BITS];
            prod_reg <= PROD_BITS'(mag) * PROD_BITS'(gain);
        end
    end

    assign prod_rnd = (PROD_BITS+1)'(prod_reg) + ((PROD_BITS+1)'(1) << (VAR_FRAC_BITS - 1));
    assign corr     = prod_rnd[VAR_FRAC_BITS +: EST_BITS+2];
    assign est_ext  = (EST_BITS+3)'(est);
    assign corr_ext = $signed({1'b0, corr});
    assign sum      = neg_reg ? est_ext - corr_ext : est_ext + corr_ext;

    always_comb begin
        if (sum[EST_BITS+2:EST_BITS-1] == '0 || sum[EST_BITS+2:EST_BITS-1] == '1) begin
            est_next = sum[EST_BITS-1:0];
        end else begin
            est_next = {sum[EST_BITS+2], {(EST_BITS-1){~sum[EST_BITS+2]}}};
        end
    end

    assign rnd = (EST_BITS+1)'(est_next) + ((EST_BITS+1)'(1) << (EST_FRAC - 1));

    always_comb begin
        if (rnd[EST_BITS] == rnd[EST_BITS-1]) begin
            est_round = rnd[EST_BITS-1:EST_FRAC];
        end else begin
            est_round = {rnd[EST_BITS], {(SAMPLE_BITS-1){~rnd[EST_BITS]}}};
        end
    end

endmodule

[rtl/sks_merge.sv]
// ----------------------------------------------------------------------------
// sks_merge
// Joins both lanes' rounded estimates into one result item and holds it.
// ----------------------------------------------------------------------------
module sks_merge
    import sks_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  logic signed [SAMPLE_BITS-1:0] lane_re,
    input  logic signed [SAMPLE_BITS-1:0] lane_im,
    output logic                          free,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_est_re,
    output logic signed [SAMPLE_BITS-1:0] m_est_im
);

    logic                          valid_reg, valid_next;
    logic signed [SAMPLE_BITS-1:0] re_reg, im_reg;

    assign free = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (load) begin
            re_reg <= lane_re;
            im_reg <= lane_im;
        end
    end

    assign m_valid  = valid_reg;
    assign m_est_re = re_reg;
    assign m_est_im = im_reg;

endmodule

[rtl/scalar_kalman_iq_smoother.sv]
// ----------------------------------------------------------------------------
// scalar_kalman_iq_smoother
// Random-walk Kalman smoothing of I and Q with one shared variance and gain.
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  s_       in         s_valid / s_ready    sample_re, sample_im, start_of_channel
//  m_       out        m_valid / m_ready    est_re, est_im
//  apb      in         psel/penable/pready  q_noise, r_noise, x_init, p_init
//
//  One item at a time: accept, prediction, 17 divider steps (none if den is zero)
//  and a done cycle, multiply, update; the next item waits for the update.
//  A result waits in the output register while the next item is worked on;
//  the update cycle stalls only if that register is still full.
//  Reset loads the register defaults and the state from them.
// ----------------------------------------------------------------------------
module scalar_kalman_iq_smoother
    import sks_pkg::*;
(
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_re,
    input  logic signed [SAMPLE_BITS-1:0] s_sample_im,
    input  logic                          s_start_of_channel,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_BITS-1:0] m_est_re,
    output logic signed [SAMPLE_BITS-1:0] m_est_im,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic        [ADDR_BITS-1:0]   paddr,
    input  logic        [31:0]            pwdata,
    output logic        [31:0]            prdata,
    output logic                          pready
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRED,
        ST_DIV,
        ST_MUL,
        ST_FIN
    } state_t;

    state_t                        state_reg;
    logic        [VAR_BITS-1:0]    q_reg, r_reg, pi_reg;
    logic signed [SAMPLE_BITS-1:0] xi_reg;
    logic signed [EST_BITS-1:0]    est_re_reg, est_im_reg;
    logic        [VAR_BITS-1:0]    var_reg;
    logic signed [SAMPLE_BITS-1:0] smp_re_reg, smp_im_reg;
    logic        [VAR_BITS-1:0]    ppred_reg;
    logic        [VPROD_BITS-1:0]  vprod_reg;

    logic                          accept;
    logic                          cfg_wr;
    cfg_reg_t                      cfg_idx;
    logic        [VAR_BITS:0]      vsum;
    logic        [VAR_BITS-1:0]    ppred_next;
    logic        [DEN_BITS-1:0]    den_next;
    logic                          div_start, div_done;
    logic        [GAIN_BITS-1:0]   gain;
    logic                          mul_en;
    logic signed [EST_BITS-1:0]    re_next, im_next;
    logic signed [SAMPLE_BITS-1:0] re_round, im_round;
    logic                          out_free, out_load;
    logic        [VPROD_BITS:0]    vprod_rnd;
    logic signed [EST_BITS-1:0]    x_init_est;

    assign accept  = s_valid && s_ready;
    assign s_ready = state_reg == ST_IDLE;
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = cfg_reg_t'(paddr[3:2]);

    always_comb begin
        unique case (cfg_idx)
            REG_Q_NOISE: prdata = 32'(q_reg);
            REG_R_NOISE: prdata = 32'(r_reg);
            REG_X_INIT:  prdata = 32'($unsigned(xi_reg));
            REG_P_INIT:  prdata = 32'(pi_reg);
            default:     prdata = '0;
        endcase
    end

    assign x_init_est = {xi_reg, {EST_FRAC{1'b0}}};
    assign vsum       = (VAR_BITS+1)'(var_reg) + (VAR_BITS+1)'(q_reg);
    assign ppred_next = vsum[VAR_BITS] ? VAR_MAX : vsum[VAR_BITS-1:0];
    assign den_next   = DEN_BITS'(ppred_next) + DEN_BITS'(r_reg);
    assign div_start  = state_reg == ST_PRED;
    assign mul_en     = state_reg == ST_MUL;
    assign out_load   = (state_reg == ST_FIN) && out_free;
    assign vprod_rnd  = (VPROD_BITS+1)'(vprod_reg) + ((VPROD_BITS+1)'(1) << (VAR_FRAC_BITS - 1));

    sks_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .ppred   (ppred_next),
        .den     (den_next),
        .done    (div_done),
        .gain    (gain)
    );

    sks_lane u_lane_re (
        .aclk      (aclk),
        .mul_en    (mul_en),
        .est       (est_re_reg),
        .sample    (smp_re_reg),
        .gain      (gain),
        .est_next  (re_next),
        .est_round (re_round)
    );

    sks_lane u_lane_im (
        .aclk      (aclk),
        .mul_en    (mul_en),
        .est       (est_im_reg),
        .sample    (smp_im_reg),
        .gain      (gain),
        .est_next  (im_next),
        .est_round (im_round)
    );

    sks_merge u_merge (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (out_load),
        .lane_re  (re_round),
        .lane_im  (im_round),
        .free     (out_free),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_est_re (m_est_re),
        .m_est_im (m_est_im)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            q_reg      <= Q_RESET;
            r_reg      <= R_RESET;
            xi_reg     <= X_RESET;
            pi_reg     <= P_RESET;
            est_re_reg <= {X_RESET, {EST_FRAC{1'b0}}};
            est_im_reg <= {X_RESET, {EST_FRAC{1'b0}}};
            var_reg    <= P_RESET;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_Q_NOISE: q_reg  <= pwdata[VAR_BITS-1:0];
                    REG_R_NOISE: r_reg  <= pwdata[VAR_BITS-1:0];
                    REG_X_INIT:  xi_reg <= pwdata[SAMPLE_BITS-1:0];
                    REG_P_INIT:  pi_reg <= pwdata[VAR_BITS-1:0];
                    default:     ;
                endcase
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (s_start_of_channel) begin
                            est_re_reg <= x_init_est;
                            est_im_reg <= x_init_est;
                            var_reg    <= pi_reg;
                        end
                        state_reg <= ST_PRED;
                    end
                end
                ST_PRED: begin
                    state_reg <= ST_DIV;
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        est_re_reg <= re_next;
                        est_im_reg <= im_next;
                        var_reg    <= vprod_rnd[VAR_FRAC_BITS +: VAR_BITS];
                        state_reg  <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
        if (accept) begin
            smp_re_reg <= s_sample_re;
            smp_im_reg <= s_sample_im;
        end
        if (state_reg == ST_PRED) begin
            ppred_reg <= ppred_next;
        end
        if (state_reg == ST_MUL) begin
            vprod_reg <= VPROD_BITS'(GAIN_ONE - gain) * VPROD_BITS'(ppred_reg);
        end
    end

`ifndef SYNTHESIS
    a_accept_pred: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_PRED)
        else $error("item accepted without starting prediction");
    a_done_in_div: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == ST_DIV)
        else $error("divider finished outside the divide state");
    a_result_from_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg == ST_FIN))
        else $error("result item appeared without an update");
`endif

endmodule

[test/scalar_kalman_iq_smoother_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// scalar_kalman_iq_smoother_test
// Self-checking bench for the I/Q Kalman smoother. A directed table covers
// the field extremes, zero measurement noise, a zero gain denominator and
// variance saturation; random items follow under varying register settings
// and handshake idling. Each result is checked against an expected value in
// the table or against an in-bench model of the fixed-point filter.
// ----------------------------------------------------------------------------
module scalar_kalman_iq_smoother_test;
    import sks_pkg::*;

    localparam int     CLK_PERIOD    = 20;
    localparam int     RESET_CYCLES  = 12;
    localparam int     CYCLE_LIMIT   = 400000;
    localparam int     DRAIN_CYCLES  = 64;
    localparam int     SEGMENTS      = 8;
    localparam int     SEGMENT_ITEMS = 160;
    localparam longint UNITY         = longint'(1) << VAR_FRAC_BITS;
    localparam longint FRAC_MASK     = UNITY - 1;
    localparam longint VAR_LIMIT     = (longint'(1) << VAR_BITS) - 1;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SEND,
        IDLE_RECV,
        IDLE_BOTH
    } idle_mode_t;

    typedef enum logic {
        ROW_CFG,
        ROW_ITEM
    } row_kind_t;

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] re;
        logic signed [SAMPLE_BITS-1:0] im;
    } iq_t;

    typedef struct {
        row_kind_t   kind;
        cfg_reg_t    sel;
        logic [31:0] value;
        iq_t         sample;
        logic        soc;
        bit          typed;
        iq_t         want;
    } plan_row_t;

    logic                          aclk               = 1'b0;
    logic                          aresetn            = 1'b0;
    logic                          s_valid            = 1'b0;
    logic                          s_ready;
    logic signed [SAMPLE_BITS-1:0] s_sample_re        = '0;
    logic signed [SAMPLE_BITS-1:0] s_sample_im        = '0;
    logic                          s_start_of_channel = 1'b0;
    logic                          m_valid;
    logic                          m_ready            = 1'b0;
    logic signed [SAMPLE_BITS-1:0] m_est_re;
    logic signed [SAMPLE_BITS-1:0] m_est_im;
    logic                          psel               = 1'b0;
    logic                          penable            = 1'b0;
    logic                          pwrite             = 1'b0;
    logic        [ADDR_BITS-1:0]   paddr              = '0;
    logic        [31:0]            pwdata             = '0;
    logic        [31:0]            prdata;
    logic                          pready;

    // model copy of the registers and the filter state
    logic [VAR_BITS-1:0]    q_reg;
    logic [VAR_BITS-1:0]    r_reg;
    logic [SAMPLE_BITS-1:0] x0_reg;
    logic [VAR_BITS-1:0]    p0_reg;
    longint                 est_re_acc;
    longint                 est_im_acc;
    longint                 var_acc;

    iq_t        est_fifo[$];
    iq_t        est_head;
    plan_row_t  directed_plan[$];
    idle_mode_t idle_mode   = IDLE_NONE;
    int         send_pct    = 0;
    int         recv_pct    = 0;
    int         fail_count  = 0;
    int         cycle_count = 0;
    int         level_re    = 0;
    int         level_im    = 0;

    scalar_kalman_iq_smoother u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_sample_re       (s_sample_re),
        .s_sample_im       (s_sample_im),
        .s_start_of_channel(s_start_of_channel),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_est_re          (m_est_re),
        .m_est_im          (m_est_im),
        .psel              (psel),
        .penable           (penable),
        .pwrite            (pwrite),
        .paddr             (paddr),
        .pwdata            (pwdata),
        .prdata            (prdata),
        .pready            (pready)
    );

    initial begin
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    function automatic longint sat_signed(longint v, int bits);
        longint hi;
        longint lo;
        hi = (longint'(1) <<< (bits - 1)) - 1;
        lo = -hi - 1;
        return (v > hi) ? hi : ((v < lo) ? lo : v);
    endfunction

    // correction rounded on the magnitude, ties away from zero
    function automatic longint correct_estimate(longint est, logic signed [SAMPLE_BITS-1:0] z,
                                                longint gain);
        longint diff;
        longint mag;
        longint corr;
        diff = longint'(z) * (longint'(1) << EST_FRAC) - est;
        mag  = (diff < 0) ? -diff : diff;
        corr = (mag >>> VAR_FRAC_BITS) * gain
             + (((mag & FRAC_MASK) * gain + UNITY / 2) >>> VAR_FRAC_BITS);
        return sat_signed((diff < 0) ? est - corr : est + corr, EST_BITS);
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] to_output(longint est);
        return SAMPLE_BITS'(sat_signed((est + (longint'(1) << (EST_FRAC - 1))) >>> EST_FRAC,
                                       SAMPLE_BITS));
    endfunction

    function automatic void reload_channel();
        est_re_acc = longint'($signed(x0_reg)) * (longint'(1) << EST_FRAC);
        est_im_acc = est_re_acc;
        var_acc    = longint'(p0_reg);
    endfunction

    function automatic void shadow_reg(cfg_reg_t sel, logic [31:0] v);
        case (sel)
            REG_Q_NOISE: q_reg  = v[VAR_BITS-1:0];
            REG_R_NOISE: r_reg  = v[VAR_BITS-1:0];
            REG_X_INIT:  x0_reg = v[SAMPLE_BITS-1:0];
            REG_P_INIT:  p0_reg = v[VAR_BITS-1:0];
            default: ;
        endcase
    endfunction

    function automatic iq_t kalman_update(iq_t z, logic soc);
        longint ppred;
        longint den;
        longint gain;
        iq_t    res;
        if (soc) begin
            reload_channel();
        end
        ppred = var_acc + longint'(q_reg);
        if (ppred > VAR_LIMIT) begin
            ppred = VAR_LIMIT;
        end
        den  = ppred + longint'(r_reg);
        gain = (den == 0) ? 0 : (ppred << VAR_FRAC_BITS) / den;
        if (gain > UNITY) begin
            gain = UNITY;
        end
        est_re_acc = correct_estimate(est_re_acc, z.re, gain);
        est_im_acc = correct_estimate(est_im_acc, z.im, gain);
        var_acc    = (((UNITY - gain) * ppred + UNITY / 2) >> VAR_FRAC_BITS) & VAR_LIMIT;
        res.re     = to_output(est_re_acc);
        res.im     = to_output(est_im_acc);
        return res;
    endfunction

    function automatic iq_t iq(int re, int im);
        iq_t v;
        v.re = SAMPLE_BITS'(re);
        v.im = SAMPLE_BITS'(im);
        return v;
    endfunction

    function automatic logic [31:0] random_var();
        case ($urandom_range(9))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return 32'(VAR_MAX);
            3:       return 32'($urandom_range(1023, 1));
            4, 5:    return 32'($urandom_range(24'h3FFFF, 24'h1000));
            default: return $urandom & 32'(VAR_MAX);
        endcase
    endfunction

    function automatic logic signed [SAMPLE_BITS-1:0] noisy(int centre);
        int v;
        v = centre + int'($urandom_range(2047)) - 1024;
        return SAMPLE_BITS'(sat_signed(longint'(v), SAMPLE_BITS));
    endfunction

    function automatic iq_t random_iq();
        iq_t z;
        case ($urandom_range(9))
            0: begin
                z.re = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
                z.im = $urandom_range(1) ? 16'sh7FFF : 16'sh8000;
            end
            1, 2, 3, 4: begin
                z.re = noisy(level_re);
                z.im = noisy(level_im);
            end
            default: z = iq_t'($urandom);
        endcase
        return z;
    endfunction

    task automatic add_cfg(cfg_reg_t sel, logic [31:0] value);
        plan_row_t row;
        row = '{ROW_CFG, sel, value, iq_t'(0), 1'b0, 1'b0, iq_t'(0)};
        directed_plan.insert(directed_plan.size(), row);
    endtask

    task automatic add_item(iq_t z, logic soc, bit typed, iq_t want);
        plan_row_t row;
        row = '{ROW_ITEM, REG_Q_NOISE, 32'd0, z, soc, typed, want};
        directed_plan.insert(directed_plan.size(), row);
    endtask

    // entered and left just after a falling edge
    task automatic push_sample(iq_t z, logic soc, bit typed, iq_t want);
        iq_t predicted;
        while (send_pct != 0 && $urandom_range(99) < send_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid            <= 1'b1;
        s_sample_re        <= z.re;
        s_sample_im        <= z.im;
        s_start_of_channel <= soc;
        do @(posedge aclk); while (!s_ready);
        predicted = kalman_update(z, soc);
        est_fifo.insert(est_fifo.size(), typed ? want : predicted);
        @(negedge aclk);
    endtask

    task automatic wait_idle();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (est_fifo.size() != 0) begin
            @(negedge aclk);
        end
    endtask

    task automatic reg_write(cfg_reg_t sel, logic [31:0] v);
        logic [31:0] mask;
        mask    = (sel == REG_X_INIT) ? 32'(16'hFFFF) : 32'(VAR_MAX);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(4 * int'(sel));
        pwdata  <= v;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        shadow_reg(sel, v);
        @(negedge aclk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        if (((prdata ^ v) & mask) != 0) begin
            $display("%0t: %s read back expected %h actual %h",
                     $time, sel.name(), v & mask, prdata & mask);
            fail_count++;
        end
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    always @(negedge aclk) begin
        m_ready <= !(recv_pct != 0 && $urandom_range(99) < recv_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (est_fifo.size() == 0) begin
                $display("%0t: unexpected item est_re %0d est_im %0d",
                         $time, m_est_re, m_est_im);
                fail_count++;
            end else begin
                est_head = est_fifo.pop_front();
                if (m_est_re !== est_head.re) begin
                    $display("%0t: est_re expected %0d actual %0d",
                             $time, est_head.re, m_est_re);
                    fail_count++;
                end
                if (m_est_im !== est_head.im) begin
                    $display("%0t: est_im expected %0d actual %0d",
                             $time, est_head.im, m_est_im);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        q_reg  = Q_RESET;
        r_reg  = R_RESET;
        x0_reg = X_RESET;
        p0_reg = P_RESET;
        reload_channel();

        // reset defaults
        add_item(iq(0, 0), 1'b0, 1'b0, iq(0, 0));
        add_item(iq(32767, -32768), 1'b0, 1'b0, iq(0, 0));
        add_item(iq(-32768, 32767), 1'b1, 1'b0, iq(0, 0));
        // zero r: gain of one, estimate jumps to the sample
        add_cfg(REG_R_NOISE, 32'd0);
        add_item(iq(32767, -32768), 1'b1, 1'b1, iq(32767, -32768));
        add_item(iq(-32768, 32767), 1'b0, 1'b1, iq(-32768, 32767));
        add_item(iq(-1, 1), 1'b0, 1'b1, iq(-1, 1));
        add_item(iq(21845, -21846), 1'b0, 1'b1, iq(21845, -21846));
        // zero denominator: estimates hold at x_init
        add_cfg(REG_Q_NOISE, 32'd0);
        add_cfg(REG_P_INIT, 32'd0);
        add_cfg(REG_X_INIT, 32'h0000_8000);
        add_item(iq(100, 200), 1'b1, 1'b1, iq(-32768, -32768));
        add_item(iq(32767, 32767), 1'b0, 1'b1, iq(-32768, -32768));
        add_item(iq(-1, -1), 1'b0, 1'b1, iq(-32768, -32768));
        // variance saturation
        add_cfg(REG_Q_NOISE, 32'(VAR_MAX));
        add_cfg(REG_R_NOISE, 32'(VAR_MAX));
        add_cfg(REG_X_INIT, 32'h0000_7FFF);
        add_cfg(REG_P_INIT, 32'(VAR_MAX));
        add_item(iq(-32768, -32768), 1'b1, 1'b0, iq(0, 0));
        add_item(iq(32767, -32768), 1'b0, 1'b0, iq(0, 0));
        add_item(iq(0, 0), 1'b0, 1'b0, iq(0, 0));
        // smallest non-zero noise terms
        add_cfg(REG_Q_NOISE, 32'd1);
        add_cfg(REG_R_NOISE, 32'd1);
        add_cfg(REG_P_INIT, 32'd1);
        add_cfg(REG_X_INIT, 32'd0);
        add_item(iq(12345, -12345), 1'b1, 1'b0, iq(0, 0));
        add_item(iq(-32768, 32767), 1'b0, 1'b0, iq(0, 0));
        add_item(iq(7, -7), 1'b0, 1'b0, iq(0, 0));
        // zero q
        add_cfg(REG_Q_NOISE, 32'd0);
        add_cfg(REG_R_NOISE, 32'd65536);
        add_cfg(REG_P_INIT, 32'd65536);
        add_cfg(REG_X_INIT, 32'h0000_FFFF);
        add_item(iq(1000, -1000), 1'b1, 1'b0, iq(0, 0));
        add_item(iq(1000, -1000), 1'b0, 1'b0, iq(0, 0));
        add_item(iq(-32768, 32767), 1'b0, 1'b0, iq(0, 0));
        // default noise terms with x_init of 0x1234, channel restarts mid-stream
        add_cfg(REG_Q_NOISE, 32'd655);
        add_cfg(REG_X_INIT, 32'h0000_1234);
        add_item(iq(20000, -20000), 1'b1, 1'b0, iq(0, 0));
        add_item(iq(20000, -20000), 1'b0, 1'b0, iq(0, 0));
        add_item(iq(-5, 5), 1'b1, 1'b0, iq(0, 0));

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (directed_plan[i]) begin
            if (directed_plan[i].kind == ROW_CFG) begin
                wait_idle();
                reg_write(directed_plan[i].sel, directed_plan[i].value);
            end else begin
                push_sample(directed_plan[i].sample, directed_plan[i].soc,
                            directed_plan[i].typed, directed_plan[i].want);
            end
        end

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            wait_idle();
            idle_mode = idle_mode_t'(seg % 4);
            case (idle_mode)
                IDLE_SEND: begin send_pct = 58; recv_pct = 0;  end
                IDLE_RECV: begin send_pct = 0;  recv_pct = 58; end
                IDLE_BOTH: begin send_pct = 34; recv_pct = 34; end
                default:   begin send_pct = 0;  recv_pct = 0;  end
            endcase
            reg_write(REG_Q_NOISE, random_var());
            reg_write(REG_R_NOISE, random_var());
            reg_write(REG_X_INIT, $urandom & 32'h0000_FFFF);
            reg_write(REG_P_INIT, random_var());
            level_re = int'($urandom_range(65535)) - 32768;
            level_im = int'($urandom_range(65535)) - 32768;
            for (int n = 0; n < SEGMENT_ITEMS; n++) begin
                push_sample(random_iq(), (n == 0) || ($urandom_range(15) == 0),
                            1'b0, iq(0, 0));
            end
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
